[design/mho_pkg.sv]
// Shared constants, types and arithmetic helpers for the mecanum heading odometry block.
// Depends on nothing.
package mho_pkg;

	localparam int SPEED_W           = 16;
	localparam int ANGLE_W           = 16;
	localparam int POS_W             = 48;
	localparam int CORDIC_STAGES_DEF = 16;
	localparam int ACC_WIDTH_DEF     = 48;

	// vy and vx are sums of four Q8.8 speeds
	localparam int VEL_W   = SPEED_W + 2;
	// folded angle, within plus or minus a quarter turn in Q7.6
	localparam int RED_W   = 14;
	// CORDIC word, Q2.30
	localparam int CW      = 32;
	localparam int ATAN_LEN = 24;
	localparam int ATAN_IW  = 5;

	// Q1.15 coefficients, multiplied a 4 bit digit at a time
	localparam int COEF_W     = 16;
	localparam int FRAC_SHIFT = 15;
	localparam int DIGIT_W    = 4;
	localparam int N_DIGITS   = COEF_W / DIGIT_W;
	localparam int PP_W       = VEL_W + DIGIT_W + 1;
	localparam int PROD_W     = 36;

	localparam logic signed [CW-1:0] CORDIC_GAIN_Q30   = CW'(652032874);
	localparam logic signed [19:0]   DEG_Q6_TO_RAD_Q30 = 20'sd292818;

	localparam logic signed [ANGLE_W:0] FULL_TURN_Q6    = (ANGLE_W+1)'(23040);
	localparam logic signed [ANGLE_W:0] HALF_TURN_Q6    = (ANGLE_W+1)'(11520);
	localparam logic signed [ANGLE_W:0] QUARTER_TURN_Q6 = (ANGLE_W+1)'(5760);

	typedef struct packed {
		logic                    flip;
		logic signed [RED_W-1:0] r;
	} fold_t;

	function automatic logic signed [CW-1:0] atan_q30(input logic [ATAN_IW-1:0] i);
		logic signed [CW-1:0] v;
		case (i)
			5'd0:    v = CW'(843314857);
			5'd1:    v = CW'(497837829);
			5'd2:    v = CW'(263043837);
			5'd3:    v = CW'(133525159);
			5'd4:    v = CW'(67021687);
			5'd5:    v = CW'(33543516);
			5'd6:    v = CW'(16775851);
			5'd7:    v = CW'(8388437);
			5'd8:    v = CW'(4194283);
			5'd9:    v = CW'(2097149);
			5'd10:   v = CW'(1048576);
			5'd11:   v = CW'(524288);
			5'd12:   v = CW'(262144);
			5'd13:   v = CW'(131072);
			5'd14:   v = CW'(65536);
			5'd15:   v = CW'(32768);
			5'd16:   v = CW'(16384);
			5'd17:   v = CW'(8192);
			5'd18:   v = CW'(4096);
			5'd19:   v = CW'(2048);
			5'd20:   v = CW'(1024);
			5'd21:   v = CW'(512);
			5'd22:   v = CW'(256);
			5'd23:   v = CW'(128);
			default: v = '0;
		endcase
		return v;
	endfunction

	// wrap to [-180, 180) degrees, then fold into [-90, 90]; flip marks a negated cosine
	function automatic fold_t fold_angle(input logic signed [ANGLE_W-1:0] a);
		logic signed [ANGLE_W:0] r;
		fold_t f;
		r = (ANGLE_W+1)'(a);
		if (r >= FULL_TURN_Q6) begin
			r = r - FULL_TURN_Q6;
		end else if (r <= -FULL_TURN_Q6) begin
			r = r + FULL_TURN_Q6;
		end
		if (r >= HALF_TURN_Q6) begin
			r = r - FULL_TURN_Q6;
		end else if (r < -HALF_TURN_Q6) begin
			r = r + FULL_TURN_Q6;
		end
		f.flip = 1'b0;
		if (r > QUARTER_TURN_Q6) begin
			r = HALF_TURN_Q6 - r;
			f.flip = 1'b1;
		end else if (r < -QUARTER_TURN_Q6) begin
			r = -HALF_TURN_Q6 - r;
			f.flip = 1'b1;
		end
		f.r = r[RED_W-1:0];
		return f;
	endfunction

	// Q2.30 to Q1.15, round half up, saturate
	function automatic logic signed [COEF_W-1:0] q30_to_q15(input logic signed [CW-1:0] v);
		logic signed [CW:0]            t;
		logic signed [CW-FRAC_SHIFT:0] s;
		logic signed [COEF_W-1:0]      q;
		t = (CW+1)'(v) + (CW+1)'(1 << (FRAC_SHIFT - 1));
		s = t[CW:FRAC_SHIFT];
		if (s > (CW-FRAC_SHIFT+1)'(32767)) begin
			q = COEF_W'(32767);
		end else if (s < -(CW-FRAC_SHIFT+1)'(32768)) begin
			q = COEF_W'(-32768);
		end else begin
			q = s[COEF_W-1:0];
		end
		return q;
	endfunction

endpackage

[design/mecanum_heading_odometry.sv]
// Mecanum wheel dead-reckoning odometry: top level, CORDIC lanes, digit-serial products.
// Depends on mho_pkg.
//
// Usage:
//  Tick channel (tick_valid / tick_stall): four Q8.8 wheel speeds and two Q9.6 headings.
//  Heading A drives the forward terms, heading B the sideways terms.
//  Position channel (pos_valid / pos_stall): world X and Y, Q25.23, saturating.
//  A word is taken at a clock edge with valid high and stall low.
//  pos_valid rises once the taken tick has passed the angle fold, the radian scale, the CORDIC
//  iterations (one per cycle for both headings side by side), rounding, four radix-16
//  multiply steps and the saturating add, which waits while the output word is stalled.
//  A new tick is taken only after the last one has finished its final add;
//  tick_stall is high while a tick is in work.
//  A finished position waits in its output register; the next tick is taken meanwhile
//  and only its final add waits for the output register to drain.
//  Reset clears both accumulators to zero and drops pos_valid.
//  Positions narrower than the accumulator carry its low bits; wider ones are sign
//  extended.
module mecanum_heading_odometry #(
	parameter int CORDIC_STAGES = mho_pkg::CORDIC_STAGES_DEF,
	parameter int ACC_WIDTH     = mho_pkg::ACC_WIDTH_DEF
) (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  logic                                  tick_valid,
	output logic                                  tick_stall,
	input  logic signed [mho_pkg::SPEED_W-1:0]    wheel_one_speed,
	input  logic signed [mho_pkg::SPEED_W-1:0]    wheel_two_speed,
	input  logic signed [mho_pkg::SPEED_W-1:0]    wheel_three_speed,
	input  logic signed [mho_pkg::SPEED_W-1:0]    wheel_four_speed,
	input  logic signed [mho_pkg::ANGLE_W-1:0]    heading_a,
	input  logic signed [mho_pkg::ANGLE_W-1:0]    heading_b,
	output logic                                  pos_valid,
	input  logic                                  pos_stall,
	output logic signed [mho_pkg::POS_W-1:0]      position_x,
	output logic signed [mho_pkg::POS_W-1:0]      position_y
);
	import mho_pkg::*;

	localparam int N_ROT = (CORDIC_STAGES > ATAN_LEN) ? ATAN_LEN : CORDIC_STAGES;
	localparam int SUM_W = ((ACC_WIDTH > PROD_W) ? ACC_WIDTH : PROD_W) + 1;
	localparam int EXT_W = (ACC_WIDTH > POS_W) ? ACC_WIDTH : POS_W;
	localparam logic signed [SUM_W-1:0] ACC_MAX =
		{{(SUM_W-ACC_WIDTH+1){1'b0}}, {(ACC_WIDTH-1){1'b1}}};
	localparam logic signed [SUM_W-1:0] ACC_MIN = ~ACC_MAX;

	localparam logic [2:0] ST_IDLE = 3'd0;
	localparam logic [2:0] ST_RED  = 3'd1;
	localparam logic [2:0] ST_RAD  = 3'd2;
	localparam logic [2:0] ST_ROT  = 3'd3;
	localparam logic [2:0] ST_RND  = 3'd4;
	localparam logic [2:0] ST_MUL  = 3'd5;
	localparam logic [2:0] ST_ACC  = 3'd6;

	logic [2:0]               state_q;
	logic [ATAN_IW-1:0]       cnt_q;

	logic signed [SPEED_W-1:0] w1_q, w2_q, w3_q, w4_q;
	logic signed [ANGLE_W-1:0] ha_q, hb_q;
	logic signed [VEL_W-1:0]   vy_q, vx_q;

	// lane 0 carries heading A, lane 1 heading B
	logic signed [RED_W-1:0]  r_q [2];
	logic                     flip_q [2];
	logic signed [CW-1:0]     x_q [2];
	logic signed [CW-1:0]     y_q [2];
	logic signed [CW-1:0]     z_q [2];
	logic signed [CW-1:0]     x_nxt [2];
	logic signed [CW-1:0]     y_nxt [2];
	logic signed [CW-1:0]     z_nxt [2];
	logic signed [CW-1:0]     at_cur;
	fold_t                    fold_a, fold_b;

	logic signed [COEF_W-1:0] s_rnd [2];
	logic signed [COEF_W-1:0] c_rnd [2];

	logic [COEF_W-1:0]        sa_sr_q, sb_sr_q, ca_sr_q, cb_sr_q;
	logic signed [DIGIT_W:0]  dig_sa, dig_sb, dig_ca, dig_cb;
	logic signed [PP_W-1:0]   pp_y, pp_x;
	logic signed [PROD_W-1:0] psum_y_q, psum_x_q;

	logic signed [ACC_WIDTH-1:0] x_acc_q, y_acc_q;
	logic signed [ACC_WIDTH-1:0] x_sat, y_sat;
	logic signed [EXT_W-1:0]     x_ext, y_ext;
	logic                        out_valid_q;
	logic signed [POS_W-1:0]     pos_x_q, pos_y_q;
	logic                        tick_take, slot_free;

	function automatic logic signed [ACC_WIDTH-1:0] sat_add(
		input logic signed [ACC_WIDTH-1:0] acc,
		input logic signed [PROD_W-1:0]    d
	);
		logic signed [SUM_W-1:0]     s;
		logic signed [ACC_WIDTH-1:0] q;
		s = SUM_W'(acc) + SUM_W'(d);
		if (s > ACC_MAX) begin
			q = ACC_MAX[ACC_WIDTH-1:0];
		end else if (s < ACC_MIN) begin
			q = ACC_MIN[ACC_WIDTH-1:0];
		end else begin
			q = s[ACC_WIDTH-1:0];
		end
		return q;
	endfunction

	assign tick_stall = (state_q != ST_IDLE);
	assign tick_take  = tick_valid && !tick_stall;
	assign slot_free  = !out_valid_q || !pos_stall;

	assign fold_a = fold_angle(ha_q);
	assign fold_b = fold_angle(hb_q);
	assign at_cur = atan_q30(cnt_q);

	always_comb begin
		for (int l = 0; l < 2; l++) begin
			if (!z_q[l][CW-1]) begin
				x_nxt[l] = x_q[l] - (y_q[l] >>> cnt_q);
				y_nxt[l] = y_q[l] + (x_q[l] >>> cnt_q);
				z_nxt[l] = z_q[l] - at_cur;
			end else begin
				x_nxt[l] = x_q[l] + (y_q[l] >>> cnt_q);
				y_nxt[l] = y_q[l] - (x_q[l] >>> cnt_q);
				z_nxt[l] = z_q[l] + at_cur;
			end
			s_rnd[l] = q30_to_q15(y_q[l]);
			c_rnd[l] = q30_to_q15(x_q[l]);
		end
	end

	// top digit of each coefficient is signed and comes first
	always_comb begin
		if (cnt_q == '0) begin
			dig_sa = {sa_sr_q[COEF_W-1], sa_sr_q[COEF_W-1 -: DIGIT_W]};
			dig_sb = {sb_sr_q[COEF_W-1], sb_sr_q[COEF_W-1 -: DIGIT_W]};
			dig_ca = {ca_sr_q[COEF_W-1], ca_sr_q[COEF_W-1 -: DIGIT_W]};
			dig_cb = {cb_sr_q[COEF_W-1], cb_sr_q[COEF_W-1 -: DIGIT_W]};
		end else begin
			dig_sa = {1'b0, sa_sr_q[COEF_W-1 -: DIGIT_W]};
			dig_sb = {1'b0, sb_sr_q[COEF_W-1 -: DIGIT_W]};
			dig_ca = {1'b0, ca_sr_q[COEF_W-1 -: DIGIT_W]};
			dig_cb = {1'b0, cb_sr_q[COEF_W-1 -: DIGIT_W]};
		end
	end

	assign pp_y = PP_W'(vy_q * dig_sa) + PP_W'(vx_q * dig_sb);
	assign pp_x = PP_W'(vx_q * dig_cb) + PP_W'(vy_q * dig_ca);

	assign x_sat = sat_add(x_acc_q, psum_x_q);
	assign y_sat = sat_add(y_acc_q, psum_y_q);
	assign x_ext = EXT_W'(x_sat);
	assign y_ext = EXT_W'(y_sat);

	// control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			cnt_q       <= '0;
			x_acc_q     <= '0;
			y_acc_q     <= '0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (tick_take) begin
						state_q <= ST_RED;
					end
				end
				ST_RED: begin
					state_q <= ST_RAD;
				end
				ST_RAD: begin
					cnt_q   <= '0;
					state_q <= ST_ROT;
				end
				ST_ROT: begin
					if (cnt_q == ATAN_IW'(N_ROT - 1)) begin
						cnt_q   <= '0;
						state_q <= ST_RND;
					end else begin
						cnt_q <= cnt_q + 1'b1;
					end
				end
				ST_RND: begin
					cnt_q   <= '0;
					state_q <= ST_MUL;
				end
				ST_MUL: begin
					if (cnt_q == ATAN_IW'(N_DIGITS - 1)) begin
						cnt_q   <= '0;
						state_q <= ST_ACC;
					end else begin
						cnt_q <= cnt_q + 1'b1;
					end
				end
				ST_ACC: begin
					if (slot_free) begin
						x_acc_q     <= x_sat;
						y_acc_q     <= y_sat;
						state_q     <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// output word flag: a new word may replace one taken at the same edge
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (state_q == ST_ACC && slot_free) begin
			out_valid_q <= 1'b1;
		end else if (!pos_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	// datapath
	always_ff @(posedge clk) begin
		if (tick_take) begin
			w1_q <= wheel_one_speed;
			w2_q <= wheel_two_speed;
			w3_q <= wheel_three_speed;
			w4_q <= wheel_four_speed;
			ha_q <= heading_a;
			hb_q <= heading_b;
		end
		case (state_q)
			ST_RED: begin
				vy_q      <= VEL_W'(w1_q) - VEL_W'(w2_q) - VEL_W'(w3_q) + VEL_W'(w4_q);
				vx_q      <= VEL_W'(w3_q) + VEL_W'(w4_q) - VEL_W'(w1_q) - VEL_W'(w2_q);
				r_q[0]    <= fold_a.r;
				flip_q[0] <= fold_a.flip;
				r_q[1]    <= fold_b.r;
				flip_q[1] <= fold_b.flip;
			end
			ST_RAD: begin
				for (int l = 0; l < 2; l++) begin
					x_q[l] <= CORDIC_GAIN_Q30;
					y_q[l] <= '0;
					z_q[l] <= CW'(CW'(r_q[l]) * CW'(DEG_Q6_TO_RAD_Q30));
				end
			end
			ST_ROT: begin
				for (int l = 0; l < 2; l++) begin
					x_q[l] <= x_nxt[l];
					y_q[l] <= y_nxt[l];
					z_q[l] <= z_nxt[l];
				end
			end
			ST_RND: begin
				sa_sr_q  <= s_rnd[0];
				ca_sr_q  <= flip_q[0] ? -c_rnd[0] : c_rnd[0];
				sb_sr_q  <= s_rnd[1];
				cb_sr_q  <= flip_q[1] ? -c_rnd[1] : c_rnd[1];
				psum_y_q <= '0;
				psum_x_q <= '0;
			end
			ST_MUL: begin
				// Horner over the coefficient digits, most significant first
				psum_y_q <= (psum_y_q <<< DIGIT_W) + PROD_W'(pp_y);
				psum_x_q <= (psum_x_q <<< DIGIT_W) + PROD_W'(pp_x);
				sa_sr_q  <= sa_sr_q << DIGIT_W;
				sb_sr_q  <= sb_sr_q << DIGIT_W;
				ca_sr_q  <= ca_sr_q << DIGIT_W;
				cb_sr_q  <= cb_sr_q << DIGIT_W;
			end
			ST_ACC: begin
				if (slot_free) begin
					pos_x_q <= x_ext[POS_W-1:0];
					pos_y_q <= y_ext[POS_W-1:0];
				end
			end
			default: begin
			end
		endcase
	end

	assign pos_valid  = out_valid_q;
	assign position_x = pos_x_q;
	assign position_y = pos_y_q;

	a_tick_starts_work: assert property (@(posedge clk) disable iff (!arst_n)
		tick_take |=> state_q == ST_RED)
		else $error("taken tick did not start the fold step");

	a_valid_from_acc: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(pos_valid) |-> $past(state_q == ST_ACC))
		else $error("position word appeared without a final add");

	a_acc_held_on_stall: assert property (@(posedge clk) disable iff (!arst_n)
		pos_valid && pos_stall |=> $stable(x_acc_q) && $stable(y_acc_q))
		else $error("accumulator moved while its word was stalled");

	a_digit_bound: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_MUL |-> cnt_q < ATAN_IW'(N_DIGITS))
		else $error("multiply digit count out of range");

endmodule

[test/tb_top.sv]
// Testbench for mecanum_heading_odometry: random and directed ticks, in-order position checks.
// Depends on mho_pkg and the block's RTL; holds its own fixed-point predictor in a scoreboard.
module tb_top;

	localparam int     WATCHDOG_LIMIT = 2000;
	localparam int     LONG_HOLD      = 400;
	localparam int     DRAIN_CYCLES   = 60;
	localparam int     RANDOM_TICKS   = 1600;
	localparam int     FINAL_TICKS    = 32;
	localparam int     HOLD_AT        = 500;
	localparam int     PAUSE_AT       = 1000;
	localparam int     CORDIC_N       = mho_pkg::CORDIC_STAGES_DEF;
	localparam int     ACC_W          = mho_pkg::ACC_WIDTH_DEF;
	localparam longint ACC_MAX        = (64'sd1 <<< (ACC_W - 1)) - 1;
	localparam longint ACC_MIN        = -ACC_MAX - 1;
	localparam longint Q15_MAX        = 32767;
	localparam longint Q15_MIN        = -32768;
	localparam int     ANGLE_LIMIT    = 23040;

	localparam longint ARCTAN_Q30 [0:23] = '{
		843314857, 497837829, 263043837, 133525159, 67021687, 33543516,
		16775851, 8388437, 4194283, 2097149, 1048576, 524288,
		262144, 131072, 65536, 32768, 16384, 8192,
		4096, 2048, 1024, 512, 256, 128
	};

	typedef struct {
		logic signed [mho_pkg::SPEED_W-1:0] w1, w2, w3, w4;
		logic signed [mho_pkg::ANGLE_W-1:0] ha, hb;
	} tick_t;

	typedef struct {
		logic signed [mho_pkg::POS_W-1:0] x, y;
	} position_t;

	class odometry_scoreboard;
		longint    x_acc;
		longint    y_acc;
		position_t expected_q[$];
		int        errors;
		int        checked;

		function new();
			x_acc   = 0;
			y_acc   = 0;
			errors  = 0;
			checked = 0;
		endfunction

		function int pending();
			return expected_q.size();
		endfunction

		function longint round_q15(longint v);
			longint r;
			r = (v + 16384) >>> 15;
			if (r > Q15_MAX) r = Q15_MAX;
			if (r < Q15_MIN) r = Q15_MIN;
			return r;
		endfunction

		// heading in degrees Q9.6 to Q1.15 sine and cosine
		function void heading_sin_cos(input logic signed [mho_pkg::ANGLE_W-1:0] ang,
				output longint sn, output longint cs);
			int     r;
			bit     flip;
			longint x, y, z, dx, dy;
			r = int'(ang) % int'(mho_pkg::FULL_TURN_Q6);
			if (r >= int'(mho_pkg::HALF_TURN_Q6)) r -= int'(mho_pkg::FULL_TURN_Q6);
			if (r < -int'(mho_pkg::HALF_TURN_Q6)) r += int'(mho_pkg::FULL_TURN_Q6);
			flip = 1'b0;
			if (r > int'(mho_pkg::QUARTER_TURN_Q6)) begin
				r    = int'(mho_pkg::HALF_TURN_Q6) - r;
				flip = 1'b1;
			end else if (r < -int'(mho_pkg::QUARTER_TURN_Q6)) begin
				r    = -int'(mho_pkg::HALF_TURN_Q6) - r;
				flip = 1'b1;
			end
			z = longint'(r) * longint'(mho_pkg::DEG_Q6_TO_RAD_Q30);
			x = longint'(mho_pkg::CORDIC_GAIN_Q30);
			y = 0;
			for (int i = 0; i < CORDIC_N && i < 24; i++) begin
				dx = y >>> i;
				dy = x >>> i;
				if (z >= 0) begin
					x -= dx;
					y += dy;
					z -= ARCTAN_Q30[i];
				end else begin
					x += dx;
					y -= dy;
					z += ARCTAN_Q30[i];
				end
			end
			sn = round_q15(y);
			cs = flip ? -round_q15(x) : round_q15(x);
		endfunction

		function longint sat_add(longint acc, longint d);
			if (d > 0 && acc > ACC_MAX - d) return ACC_MAX;
			if (d < 0 && acc < ACC_MIN - d) return ACC_MIN;
			return acc + d;
		endfunction

		function void note_tick(tick_t t);
			longint    vy, vx, sa, ca, sb, cb;
			position_t p;
			vy = longint'(t.w1) - longint'(t.w2) - longint'(t.w3) + longint'(t.w4);
			vx = -(longint'(t.w1) + longint'(t.w2) - longint'(t.w3) - longint'(t.w4));
			heading_sin_cos(t.ha, sa, ca);
			heading_sin_cos(t.hb, sb, cb);
			y_acc = sat_add(y_acc, vy * sa + vx * sb);
			x_acc = sat_add(x_acc, vx * cb + vy * ca);
			p.x = mho_pkg::POS_W'(x_acc);
			p.y = mho_pkg::POS_W'(y_acc);
			expected_q.push_back(p);
		endfunction

		function void check_position(logic signed [mho_pkg::POS_W-1:0] px,
				logic signed [mho_pkg::POS_W-1:0] py);
			position_t e;
			if (expected_q.size() == 0) begin
				$error("position word with no tick outstanding: x %0d y %0d", px, py);
				errors++;
				return;
			end
			e = expected_q.pop_front();
			checked++;
			if (px !== e.x) begin
				$error("position_x: expected %0d, got %0d", e.x, px);
				errors++;
			end
			if (py !== e.y) begin
				$error("position_y: expected %0d, got %0d", e.y, py);
				errors++;
			end
		endfunction
	endclass

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic tick_valid = 1'b0;
	logic tick_stall;
	logic signed [mho_pkg::SPEED_W-1:0] wheel_one_speed = '0;
	logic signed [mho_pkg::SPEED_W-1:0] wheel_two_speed = '0;
	logic signed [mho_pkg::SPEED_W-1:0] wheel_three_speed = '0;
	logic signed [mho_pkg::SPEED_W-1:0] wheel_four_speed = '0;
	logic signed [mho_pkg::ANGLE_W-1:0] heading_a = '0;
	logic signed [mho_pkg::ANGLE_W-1:0] heading_b = '0;
	logic pos_valid;
	logic pos_stall = 1'b0;
	logic signed [mho_pkg::POS_W-1:0] position_x;
	logic signed [mho_pkg::POS_W-1:0] position_y;

	odometry_scoreboard sb = new();
	bit tx_idle_en = 1'b0;
	bit rx_idle_en = 1'b0;
	bit long_hold_req = 1'b0;
	int ticks_sent = 0;
	int climb_ticks = 0;

	mecanum_heading_odometry dut (
		.clk               (clk),
		.arst_n            (arst_n),
		.tick_valid        (tick_valid),
		.tick_stall        (tick_stall),
		.wheel_one_speed   (wheel_one_speed),
		.wheel_two_speed   (wheel_two_speed),
		.wheel_three_speed (wheel_three_speed),
		.wheel_four_speed  (wheel_four_speed),
		.heading_a         (heading_a),
		.heading_b         (heading_b),
		.pos_valid         (pos_valid),
		.pos_stall         (pos_stall),
		.position_x        (position_x),
		.position_y        (position_y)
	);

	initial begin
		forever #5 clk = ~clk;
	end

	function automatic tick_t make_tick(int a, int b, int c, int d, int e, int f);
		tick_t t;
		t.w1 = 16'(a);
		t.w2 = 16'(b);
		t.w3 = 16'(c);
		t.w4 = 16'(d);
		t.ha = 16'(e);
		t.hb = 16'(f);
		return t;
	endfunction

	function automatic logic signed [15:0] random_speed();
		case ($urandom_range(0, 7))
			0:       return 16'sh7fff;
			1:       return 16'sh8000;
			2:       return 16'(int'($urandom_range(0, 1024)) - 512);
			default: return 16'($urandom);
		endcase
	endfunction

	// near quarter-turn multiples a third of the time, otherwise anywhere in range
	function automatic logic signed [15:0] random_heading();
		int b;
		if ($urandom_range(0, 2) == 0) begin
			b = 5760 * int'($urandom_range(0, 4)) + int'($urandom_range(0, 2)) - 1;
			if (b > ANGLE_LIMIT) b = ANGLE_LIMIT;
			if (b < 0) b = 0;
			if ($urandom_range(0, 1) == 1) b = -b;
		end else begin
			b = int'($urandom_range(0, 2 * ANGLE_LIMIT)) - ANGLE_LIMIT;
		end
		return 16'(b);
	endfunction

	// call just after a rising edge; returns at the edge that takes the word
	task automatic send_tick(tick_t t);
		tick_valid        <= 1'b1;
		wheel_one_speed   <= t.w1;
		wheel_two_speed   <= t.w2;
		wheel_three_speed <= t.w3;
		wheel_four_speed  <= t.w4;
		heading_a         <= t.ha;
		heading_b         <= t.hb;
		@(posedge clk);
		while (tick_stall) @(posedge clk);
		sb.note_tick(t);
		ticks_sent++;
	endtask

	task automatic send_random_ticks();
		tick_t t;
		for (int n = 0; n < RANDOM_TICKS; n++) begin
			if (n % 50 == 0) begin
				tx_idle_en = ($urandom_range(0, 3) != 0);
				rx_idle_en = ($urandom_range(0, 3) != 0);
			end
			if (n == HOLD_AT) begin
				long_hold_req = 1'b1;
				tx_idle_en    = 1'b0;
			end
			t.w1 = random_speed();
			t.w2 = random_speed();
			t.w3 = random_speed();
			t.w4 = random_speed();
			t.ha = random_heading();
			t.hb = random_heading();
			if (n == PAUSE_AT) begin
				tick_valid <= 1'b0;
				do @(posedge clk); while (sb.pending() != 0);
			end else if (tx_idle_en && $urandom_range(0, 3) == 0) begin
				tick_valid <= 1'b0;
				repeat ($urandom_range(1, 16)) @(posedge clk);
			end
			send_tick(t);
		end
	endtask

	initial begin : position_sink
		int hold_cnt;
		hold_cnt = 0;
		forever begin
			@(posedge clk);
			if (arst_n && pos_valid && !pos_stall) sb.check_position(position_x, position_y);
			if (hold_cnt > 0) begin
				hold_cnt--;
			end else if (long_hold_req) begin
				long_hold_req = 1'b0;
				hold_cnt      = LONG_HOLD;
			end else if (rx_idle_en && $urandom_range(0, 5) == 0) begin
				hold_cnt = $urandom_range(1, 16);
			end
			pos_stall <= (hold_cnt > 0);
		end
	end

	initial begin : watchdog
		int quiet;
		quiet = 0;
		while (quiet < WATCHDOG_LIMIT) begin
			@(posedge clk);
			if ((tick_valid && !tick_stall) || (pos_valid && !pos_stall)) quiet = 0;
			else quiet++;
		end
		$display("no word moved for %0d cycles, %0d positions outstanding",
			quiet, sb.pending());
		$display("[mecanum_heading_odometry] ERROR");
		$finish;
	end

	initial begin : stimulus
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: full-scale speeds, fold and wrap boundaries, plus and minus a full turn
		send_tick(make_tick(0, 0, 0, 0, 0, 0));
		send_tick(make_tick(32767, 32767, 32767, 32767, 0, 0));
		send_tick(make_tick(-32768, -32768, -32768, -32768, 23040, -23040));
		send_tick(make_tick(32767, -32768, -32768, 32767, 5760, -5760));
		send_tick(make_tick(-32768, -32768, 32767, 32767, 5761, -5761));
		send_tick(make_tick(32767, -32768, 32767, -32768, 11520, -11520));
		send_tick(make_tick(100, -200, 300, -400, 11519, -11521));
		send_tick(make_tick(256, 256, -256, -256, 17280, -17280));
		send_tick(make_tick(-32768, 32767, 32767, -32768, 2880, -2880));
		send_tick(make_tick(1, -1, 1, -1, 1, -1));
		send_tick(make_tick(12345, -23456, 7890, -1111, 23039, -23039));
		send_tick(make_tick(32767, 0, 0, 0, 5759, -5759));
		send_tick(make_tick(0, -32768, 0, 0, 17281, -17279));
		send_tick(make_tick(0, 0, 32767, 0, 11521, -11519));
		send_tick(make_tick(0, 0, 0, -32768, 22000, -640));
		send_tick(make_tick(-1, -1, -1, -1, 21845, -21846));
		send_tick(make_tick(21845, -21846, 10922, -10923, 10922, -10923));

		send_random_ticks();

		// back to back, no idling: full-scale pushes on X, mostly forward, some back
		tx_idle_en = 1'b0;
		rx_idle_en = 1'b0;
		for (int k = 0; k < FINAL_TICKS; k++) begin
			if (k % 4 == 3) begin
				send_tick(make_tick(0, 32767, 0, -32768, 0, 0));
			end else begin
				send_tick(make_tick(0, -32768, 0, 32767, 0, 0));
			end
			climb_ticks++;
		end
		tick_valid <= 1'b0;

		while (sb.pending() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		$display("%0d ticks sent, %0d positions checked, %0d mismatching fields",
			ticks_sent, sb.checked, sb.errors);
		$display("fold and wrap edges, full-scale speeds, long output hold-off, drained pause, %0d %s",
			climb_ticks, "back-to-back full-scale ticks at the end");
		if (sb.errors == 0) begin
			$display("[mecanum_heading_odometry] OK");
		end else begin
			$display("[mecanum_heading_odometry] ERROR");
		end
		$finish;
	end

endmodule
